// ----- sv/twrc_pkg.sv -----
// Shared types and constants for the time window route checker.
// Depends on nothing; every other file uses it.
`default_nettype none

package twrc_pkg;

    localparam int TIME_BITS_DEFAULT = 24;
    localparam int LOAD_BITS_DEFAULT = 20;

    localparam int FIELD_TIME_W = 24;
    localparam int FIELD_DEMAND_W = 16;
    localparam int CAP_W = 20;

    localparam logic [CAP_W-1:0] CAP_RESET = {CAP_W{1'b1}};
    localparam logic [FIELD_TIME_W-1:0] OUT_TIME_MAX = {FIELD_TIME_W{1'b1}};

    typedef struct packed {
        logic                      visit_is_depot;
        logic [FIELD_TIME_W-1:0]   travel_time;
        logic [FIELD_TIME_W-1:0]   open_time;
        logic [FIELD_TIME_W-1:0]   close_time;
        logic [FIELD_TIME_W-1:0]   service_duration;
        logic [FIELD_DEMAND_W-1:0] demand;
        logic                      last_visit;
    } visit_t;

    typedef struct packed {
        logic [FIELD_TIME_W-1:0] service_start;
        logic                    late;
        logic                    overloaded;
        logic                    sequence_feasible;
        logic                    sequence_done;
    } result_t;

    typedef struct packed {
        logic   valid;
        visit_t data;
    } stage_t;

endpackage

`default_nettype wire

// ----- sv/twrc_visit_if.sv -----
// Visit channel: valid/ready handshake carrying one visit per transfer.
// Depends on twrc_pkg.
`default_nettype none

interface twrc_visit_if;
    logic            valid;
    logic            ready;
    twrc_pkg::visit_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/twrc_result_if.sv -----
// Result channel: valid/ready handshake carrying one result per transfer.
// Depends on twrc_pkg.
`default_nettype none

interface twrc_result_if;
    logic             valid;
    logic             ready;
    twrc_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- sv/twrc_input_stage.sv -----
// Input register of the route checker: holds one accepted visit.
// Depends on twrc_pkg and twrc_visit_if.
`default_nettype none

module twrc_input_stage (
    input  wire logic           clk,
    input  wire logic           rst_n,
    twrc_visit_if.sink          visit,
    input  wire logic           take,
    output twrc_pkg::stage_t    stage
);
    import twrc_pkg::*;

    logic   valid_reg;
    logic   valid_next;
    visit_t data_reg;
    logic   load_en;

    assign visit.ready = !valid_reg || take;
    assign load_en = visit.valid && visit.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load_en)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            data_reg <= visit.data;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.data = data_reg;

endmodule

`default_nettype wire

// ----- sv/twrc_route_core.sv -----
// Route state, time window and load checks, and the result register.
// Depends on twrc_pkg and twrc_result_if.
`default_nettype none

module twrc_route_core #(
    parameter int TIME_BITS = twrc_pkg::TIME_BITS_DEFAULT,
    parameter int LOAD_BITS = twrc_pkg::LOAD_BITS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  twrc_pkg::stage_t               stage,
    output logic                           take,
    input  wire logic                      cfg_we,
    input  wire logic [twrc_pkg::CAP_W-1:0] cfg_wdata,
    twrc_result_if.source                  result
);
    import twrc_pkg::*;

    localparam int TEW = (TIME_BITS > FIELD_TIME_W) ? TIME_BITS : FIELD_TIME_W;
    localparam int LEW = (LOAD_BITS > CAP_W) ? LOAD_BITS : CAP_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};
    localparam logic [TEW-1:0] TIME_MAX_EXT = TEW'(TIME_MAX);
    localparam logic [TEW-1:0] OUT_MAX_EXT = TEW'(OUT_TIME_MAX);

    logic [CAP_W-1:0]     capacity_reg;
    logic [TIME_BITS-1:0] departure_reg;
    logic [TIME_BITS-1:0] departure_next;
    logic [LOAD_BITS-1:0] load_reg;
    logic [LOAD_BITS-1:0] load_next;
    logic                 any_late_reg;
    logic                 any_late_next;
    logic                 any_over_reg;
    logic                 any_over_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    result_t              out_data_reg;
    result_t              out_data_next;

    logic [TEW-1:0]       travel_ext;
    logic [TEW-1:0]       ready_ext;
    logic [TEW-1:0]       service_ext;
    logic [TEW-1:0]       start_ext;
    logic [TIME_BITS-1:0] travel_c;
    logic [TIME_BITS-1:0] ready_c;
    logic [TIME_BITS-1:0] service_c;
    logic [TIME_BITS:0]   arrive_sum;
    logic [TIME_BITS-1:0] arrive;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS:0]   depart_sum;
    logic [LOAD_BITS:0]   load_sum;
    logic [LOAD_BITS-1:0] load_new;
    logic                 late;
    logic                 over;

    assign take = stage.valid && (!out_valid_reg || result.ready);

    always_comb
    begin
        travel_ext  = TEW'(stage.data.travel_time);
        ready_ext   = TEW'(stage.data.open_time);
        service_ext = TEW'(stage.data.service_duration);
        travel_c  = (travel_ext > TIME_MAX_EXT) ? TIME_MAX : travel_ext[TIME_BITS-1:0];
        ready_c   = (ready_ext > TIME_MAX_EXT) ? TIME_MAX : ready_ext[TIME_BITS-1:0];
        service_c = (service_ext > TIME_MAX_EXT) ? TIME_MAX : service_ext[TIME_BITS-1:0];

        arrive_sum = {1'b0, departure_reg} + {1'b0, travel_c};
        arrive = arrive_sum[TIME_BITS] ? TIME_MAX : arrive_sum[TIME_BITS-1:0];
        load_sum = {1'b0, load_reg} + (LOAD_BITS + 1)'(stage.data.demand);

        if (stage.data.visit_is_depot)
        begin
            start      = '0;
            depart_sum = '0;
            load_new   = '0;
        end
        else
        begin
            start      = (arrive > ready_c) ? arrive : ready_c;
            depart_sum = {1'b0, start} + {1'b0, service_c};
            load_new   = load_sum[LOAD_BITS] ? LOAD_MAX : load_sum[LOAD_BITS-1:0];
        end

        start_ext = TEW'(start);
        late = start_ext > TEW'(stage.data.close_time);
        over = LEW'(load_new) > LEW'(capacity_reg);

        out_data_next.service_start = (start_ext > OUT_MAX_EXT)
                                      ? OUT_TIME_MAX : start_ext[FIELD_TIME_W-1:0];
        out_data_next.late = late;
        out_data_next.overloaded = over;
        out_data_next.sequence_feasible = stage.data.last_visit
                                          && !(any_late_reg || late)
                                          && !(any_over_reg || over);
        out_data_next.sequence_done = stage.data.last_visit;
    end

    always_comb
    begin
        departure_next = departure_reg;
        load_next      = load_reg;
        any_late_next  = any_late_reg;
        any_over_next  = any_over_reg;
        if (take)
        begin
            if (stage.data.last_visit)
            begin
                departure_next = '0;
                load_next      = '0;
                any_late_next  = 1'b0;
                any_over_next  = 1'b0;
            end
            else
            begin
                departure_next = depart_sum[TIME_BITS] ? TIME_MAX
                                                       : depart_sum[TIME_BITS-1:0];
                load_next      = load_new;
                any_late_next  = any_late_reg || late;
                any_over_next  = any_over_reg || over;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CAP_RESET;
            departure_reg <= '0;
            load_reg      <= '0;
            any_late_reg  <= 1'b0;
            any_over_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
            departure_reg <= departure_next;
            load_reg      <= load_next;
            any_late_reg  <= any_late_next;
            any_over_reg  <= any_over_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data = out_data_reg;

endmodule

`default_nettype wire

// ----- sv/time_window_route_checker.sv -----
// Time window route checker: one visit per transfer, one result per visit.
// Path: a transferred visit passes through the input register, then the result register.
// Throughput: one visit per cycle unless the result channel stalls; state updates per visit.
// Reset (rst_n, async, active low): pipeline empty, route state and sticky flags zero,
// load capacity all ones.
// Depends on twrc_pkg, twrc_visit_if, twrc_result_if, twrc_input_stage, twrc_route_core.
`default_nettype none

module time_window_route_checker #(
    parameter int TIME_BITS = twrc_pkg::TIME_BITS_DEFAULT,
    parameter int LOAD_BITS = twrc_pkg::LOAD_BITS_DEFAULT
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    twrc_visit_if.sink                     visit,
    twrc_result_if.source                  result,
    input  wire logic                      cfg_we,
    input  wire logic [twrc_pkg::CAP_W-1:0] cfg_wdata
);
    import twrc_pkg::*;

    stage_t stage;
    logic   take;

    twrc_input_stage u_input (
        .clk   (clk),
        .rst_n (rst_n),
        .visit (visit),
        .take  (take),
        .stage (stage)
    );

    twrc_route_core #(
        .TIME_BITS (TIME_BITS),
        .LOAD_BITS (LOAD_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .stage     (stage),
        .take      (take),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .result    (result)
    );

endmodule

`default_nettype wire
